@@ hw/rtl/chunked_transfer_receiver_unit_defines.svh @@
// Assertion shorthands used by the receiver core module.
`ifndef CHUNKED_TRANSFER_RECEIVER_UNIT_DEFINES_SVH
`define CHUNKED_TRANSFER_RECEIVER_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the trigger.
`define CTR_ASSERT_NOW(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the trigger.
`define CTR_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/ctr_pkg.sv @@
`timescale 1ns / 1ps

package ctr_pkg;

  typedef enum logic [2:0] {
    OP_START   = 3'd0,
    OP_DHDR    = 3'd1,
    OP_DBYTE   = 3'd2,
    OP_END     = 3'd3,
    OP_TIMEOUT = 3'd4,
    OP_UNKNOWN = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_RUN     = 2'd0,
    ST_OK      = 2'd1,
    ST_FAIL    = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_t;

  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        v2_flag;
    logic [31:0] header_value;
    logic [31:0] packet_id;
    logic        id_length_ok;
    logic        meta_ok;
    logic [10:0] body_length;
    logic [7:0]  data_byte;
    logic        last_byte;
  } ctr_in_t;

  typedef struct packed {
    logic        byte_valid;
    logic [7:0]  byte_out;
    logic [1:0]  status;
    logic        send_nack;
    logic        send_done;
    logic [31:0] control_seq;
    logic [31:0] control_id;
  } ctr_out_t;

endpackage

@@ hw/rtl/chunked_transfer_receiver_unit.sv @@
`timescale 1ns / 1ps

// Receiver for a sequenced chunk transfer. Each item is accepted into an input register and
// decided once the core takes it from there, its result landing in an output register; a new
// item can be taken every cycle while the output side keeps up, so the sustained rate is one
// item per clock. Each item passes through the input register, and its result through the
// output register, before the result is presented. A result that is held back by the output
// side holds the input register, and the input stalls with it. The running CRC-32 and the
// sequence and byte checks all sit in the combinational logic between the two registers. Each
// item gives exactly one result, and once a final status has been reported every later result is all zero until reset.
module chunked_transfer_receiver_unit import ctr_pkg::*; #(
  parameter int MAX_CHUNK_BYTES = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  ctr_in_t  in_item,
  output logic     out_valid,
  input  logic     out_ready,
  output ctr_out_t out_item
);

  logic    hold_valid;
  ctr_in_t hold_item;
  logic    take;

  ctr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (take)
  );

  ctr_core #(
    .MAX_CHUNK_BYTES (MAX_CHUNK_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (take),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_item   (out_item)
  );

endmodule

@@ hw/rtl/ctr_crc_byte.sv @@
`timescale 1ns / 1ps

module ctr_crc_byte import ctr_pkg::*; (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  // Reflected CRC-32, one bit per step, eight steps for the byte.
  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CrcPoly : 32'd0);
    end
    crc_out = c;
  end

endmodule

@@ hw/rtl/ctr_in_stage.sv @@
`timescale 1ns / 1ps

module ctr_in_stage import ctr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  ctr_in_t in_item,
  output logic    hold_valid,
  output ctr_in_t hold_item,
  input  logic    take
);

  // The register refills in the same cycle that the core takes its item.
  assign in_ready = !hold_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item <= in_item;
    end
  end

endmodule

@@ hw/rtl/ctr_core.sv @@
`timescale 1ns / 1ps
`include "chunked_transfer_receiver_unit_defines.svh"

module ctr_core import ctr_pkg::*; #(
  parameter int MAX_CHUNK_BYTES = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     hold_valid,
  input  ctr_in_t  hold_item,
  output logic     take,
  output logic     out_valid,
  input  logic     out_ready,
  output ctr_out_t out_item
);

  localparam logic [16:0] MaxChunk = 17'(MAX_CHUNK_BYTES);

  logic        started, started_next;
  logic        end_seen, end_seen_next;
  logic        version_two, version_two_next;
  logic        finished, finished_next;
  logic        in_packet, in_packet_next;
  logic [31:0] size_expected, size_expected_next;
  logic [31:0] bytes_received, bytes_received_next;
  logic [31:0] seq_expected, seq_expected_next;
  logic [31:0] active_id, active_id_next;
  logic [31:0] crc_acc, crc_acc_next;
  logic [31:0] crc_announced, crc_announced_next;
  ctr_out_t    res;
  logic [31:0] crc_new;
  logic [31:0] bytes_inc;
  logic [31:0] seq_inc;
  logic        id_bad;
  logic        len_bad;

  ctr_crc_byte u_crc (
    .crc_in  (crc_acc),
    .data    (hold_item.data_byte),
    .crc_out (crc_new)
  );

  assign take      = hold_valid && (!out_valid || out_ready);
  assign bytes_inc = bytes_received + 32'd1;
  assign seq_inc   = seq_expected + 32'd1;
  assign id_bad    = version_two && (!hold_item.v2_flag || !hold_item.id_length_ok ||
                     hold_item.packet_id != active_id);
  assign len_bad   = hold_item.body_length == 11'd0 ||
                     {6'd0, hold_item.body_length} > MaxChunk;

  always_comb begin
    started_next        = started;
    end_seen_next       = end_seen;
    version_two_next    = version_two;
    finished_next       = finished;
    in_packet_next      = in_packet;
    size_expected_next  = size_expected;
    bytes_received_next = bytes_received;
    seq_expected_next   = seq_expected;
    active_id_next      = active_id;
    crc_acc_next        = crc_acc;
    crc_announced_next  = crc_announced;
    res                 = '0;

    if (take && !finished) begin
      unique case (hold_item.opcode)
        OP_TIMEOUT: begin
          finished_next = 1'b1;
          if (!started) begin
            res.status = ST_TIMEOUT;
          end else begin
            res.status = ST_FAIL;
            if (version_two) begin
              res.send_nack   = 1'b1;
              res.control_seq = seq_expected;
              res.control_id  = active_id;
            end
          end
        end
        OP_START: begin
          if (!started && hold_item.meta_ok) begin
            started_next       = 1'b1;
            version_two_next   = hold_item.v2_flag;
            size_expected_next = hold_item.header_value;
            active_id_next     = hold_item.v2_flag ? hold_item.packet_id : 32'd0;
          end
        end
        OP_DHDR: begin
          if (started) begin
            in_packet_next = 1'b0;
            if (!id_bad && !len_bad) begin
              if (hold_item.header_value == seq_expected) begin
                in_packet_next = 1'b1;
              end else if (hold_item.header_value > seq_expected && version_two) begin
                res.send_nack   = 1'b1;
                res.control_seq = seq_expected;
                res.control_id  = active_id;
              end
            end
          end
        end
        OP_DBYTE: begin
          if (started && in_packet) begin
            res.byte_valid      = 1'b1;
            res.byte_out        = hold_item.data_byte;
            crc_acc_next        = crc_new;
            bytes_received_next = bytes_inc;
            if (hold_item.last_byte) begin
              in_packet_next    = 1'b0;
              seq_expected_next = seq_inc;
              // The transfer closes here when END came in ahead of the last byte.
              if (end_seen && bytes_inc == size_expected) begin
                finished_next = 1'b1;
                if (crc_announced != ~crc_new) begin
                  res.status = ST_FAIL;
                end else begin
                  res.status = ST_OK;
                  if (version_two) begin
                    res.send_done   = 1'b1;
                    res.control_seq = seq_inc;
                    res.control_id  = active_id;
                  end
                end
              end
            end
          end
        end
        OP_END: begin
          if (started && !end_seen) begin
            end_seen_next      = 1'b1;
            crc_announced_next = hold_item.header_value;
            if (id_bad) begin
              finished_next = 1'b1;
              res.status    = ST_FAIL;
            end else if (bytes_received != size_expected) begin
              if (version_two) begin
                res.send_nack   = 1'b1;
                res.control_seq = seq_expected;
                res.control_id  = active_id;
              end
            end else begin
              finished_next = 1'b1;
              if (hold_item.header_value != ~crc_acc) begin
                res.status = ST_FAIL;
              end else begin
                res.status = ST_OK;
                if (version_two) begin
                  res.send_done   = 1'b1;
                  res.control_seq = seq_expected;
                  res.control_id  = active_id;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= 1'b0;
      end_seen       <= 1'b0;
      version_two    <= 1'b0;
      finished       <= 1'b0;
      in_packet      <= 1'b0;
      size_expected  <= 32'd0;
      bytes_received <= 32'd0;
      seq_expected   <= 32'd0;
      active_id      <= 32'd0;
      crc_acc        <= CrcInit;
      crc_announced  <= 32'd0;
      out_valid      <= 1'b0;
    end else begin
      started        <= started_next;
      end_seen       <= end_seen_next;
      version_two    <= version_two_next;
      finished       <= finished_next;
      in_packet      <= in_packet_next;
      size_expected  <= size_expected_next;
      bytes_received <= bytes_received_next;
      seq_expected   <= seq_expected_next;
      active_id      <= active_id_next;
      crc_acc        <= crc_acc_next;
      crc_announced  <= crc_announced_next;
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_item <= res;
    end
  end

  `CTR_ASSERT_NEXT(a_finished_sticks, finished, finished, "finished flag dropped before reset")
  `CTR_ASSERT_NEXT(a_zero_after_finish, take && finished, out_item == '0, "result after finish not zero")
  `CTR_ASSERT_NOW(a_done_means_ok, out_valid && out_item.send_done, out_item.status == ST_OK, "DONE without success")
  `CTR_ASSERT_NEXT(a_byte_counted, take && res.byte_valid, bytes_received == $past(bytes_inc), "byte count did not advance")

endmodule
